### src/oal_pkg.sv
// shared types and constants for the ordered array list engine
// no dependencies; used by oal_cell, oal_ctrl and the top level
package oal_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_PUSH = 3'd2,
    CMD_PULL = 3'd3,
    CMD_CMP  = 3'd4,
    CMD_SCAN = 3'd5
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t           cmd;
    logic [IDX_W-1:0]    target;
    logic [DATA_W-1:0]   value;
  } cell_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_REMOVE = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

endpackage

### src/oal_cell.sv
// one list cell: holds one entry and one match flag, talks to its two neighbors
// depends on oal_pkg
module oal_cell (
  input  logic                      clk,
  input  oal_pkg::cell_ctl_t        ctl,
  input  logic [oal_pkg::IDX_W-1:0] cell_idx,
  input  logic [oal_pkg::DATA_W-1:0] left_entry,
  input  logic [oal_pkg::DATA_W-1:0] right_entry,
  input  logic                      right_flag,
  output logic [oal_pkg::DATA_W-1:0] entry,
  output logic                      flag
);
  import oal_pkg::*;

  logic [DATA_W-1:0] entry_r, entry_nxt;
  logic              flag_r, flag_nxt;

  always_comb begin
    entry_nxt = entry_r;
    flag_nxt  = flag_r;
    unique case (ctl.cmd)
      CMD_HOLD: ;
      CMD_LOAD: if (cell_idx == ctl.target) entry_nxt = ctl.value;
      CMD_PUSH: entry_nxt = left_entry;
      CMD_PULL: if (cell_idx >= ctl.target) entry_nxt = right_entry;
      CMD_CMP:  flag_nxt = (entry_r == ctl.value);
      CMD_SCAN: flag_nxt = right_flag;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    flag_r  <= flag_nxt;
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule

### src/oal_ctrl.sv
// sequencer for the list engine: handshakes, entry count, scan counter, result register
// depends on oal_pkg
module oal_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  oal_pkg::op_t                in_op,
  input  logic [oal_pkg::DATA_W-1:0]  in_value,
  input  logic                        head_flag,
  output oal_pkg::cell_ctl_t          ctl,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output oal_pkg::status_t            out_status,
  output logic [oal_pkg::POS_W-1:0]   out_position,
  output logic [oal_pkg::COUNT_W-1:0] out_count
);
  import oal_pkg::*;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic full, empty, scan_last, out_free;

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign scan_last = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    pos_nxt        = pos_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    ctl.cmd        = CMD_HOLD;
    ctl.target     = '0;
    ctl.value      = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_op;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        pos_nxt  = '0;
        scan_nxt = '0;
        unique case (op_r)
          OP_APPEND, OP_INSERT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctl.cmd    = (op_r == OP_APPEND) ? CMD_LOAD : CMD_PUSH;
              ctl.target = count_r[IDX_W-1:0];
              count_nxt  = count_r + CNT_W'(1);
              status_nxt = ST_OK;
            end
            state_nxt = S_RESULT;
          end
          OP_SEARCH, OP_REMOVE: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESULT;
            end else begin
              ctl.cmd   = CMD_CMP;
              state_nxt = S_SCAN;
            end
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_SCAN: begin
        ctl.cmd = CMD_SCAN;
        priority if (head_flag) begin
          pos_nxt    = scan_r;
          status_nxt = ST_OK;
          state_nxt  = (op_r == OP_REMOVE) ? S_REMOVE : S_RESULT;
        end else if (scan_last) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESULT;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      S_REMOVE: begin
        ctl.cmd    = CMD_PULL;
        ctl.target = pos_r;
        count_nxt  = count_r - CNT_W'(1);
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = POS_W'(pos_r);
          out_count_nxt  = COUNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    scan_r       <= scan_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_count    = out_count_r;

endmodule

### src/ordered_array_list_engine.sv
// top level of the ordered array list engine: sequencer plus a row of list cells
// depends on oal_pkg, oal_cell and oal_ctrl
//
// Keeps an ordered list of up to 64 signed 32-bit values in a row of cells. Each input
// transfer carries an operation (append at end, insert at front, search, remove first
// match) and a value; each one yields exactly one result transfer with status, position
// of the first match and the count after the operation. One item is worked on at a
// time. The result register is loaded in the result state once the output register is
// free; append and insert reach it straight from the execute state, search and remove
// after the scan state (remove on a hit also after the remove state), and on an empty
// list both go to it straight from the execute state. The next item can be accepted in
// the cycle right after that load. The match flags of all cells are set together by one
// compare step and then shift one cell per cycle toward cell 0, where the sequencer looks
// for the first hit. An insert moves every cell's entry to its right neighbor and a remove
// moves the entries from the match onward one cell toward the head, all at the same edge.
// A finished result waits in the output register while the next item is taken.
module ordered_array_list_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [oal_pkg::IN_TDATA_W-1:0]    in_tdata,  // [31:0] value
  input  logic [oal_pkg::OP_W-1:0]          in_tuser,  // [1:0] operation
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [oal_pkg::OUT_TDATA_W-1:0]   out_tdata  // [1:0] status, [7:2] position,
                                                       // [14:8] count, [15] zero
);
  import oal_pkg::*;

  cell_ctl_t          ctl;
  status_t            res_status;
  logic [POS_W-1:0]   res_position;
  logic [COUNT_W-1:0] res_count;

  // per-cell entry and match flag, cell 0 is the list head
  logic [DATA_W-1:0] entry_w [CAPACITY];
  logic              flag_w  [CAPACITY];

  oal_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_op        (op_t'(in_tuser)),
    .in_value     (in_tdata[DATA_W-1:0]),
    .head_flag    (flag_w[0]),
    .ctl          (ctl),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_status   (res_status),
    .out_position (res_position),
    .out_count    (res_count)
  );

  // chain of cells: each sees its left and right neighbor, ends are closed off
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    logic              right_flag_w;

    if (i == 0) begin : g_head
      // insert at front feeds the new value into the head
      assign left_w = ctl.value;
    end else begin : g_mid_left
      assign left_w = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w      = entry_w[i];
      assign right_flag_w = 1'b0;
    end else begin : g_mid_right
      assign right_w      = entry_w[i+1];
      assign right_flag_w = flag_w[i+1];
    end

    oal_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cell_idx    (IDX_W'(i)),
      .left_entry  (left_w),
      .right_entry (right_w),
      .right_flag  (right_flag_w),
      .entry       (entry_w[i]),
      .flag        (flag_w[i])
    );
  end

  // result packing, status in the low bits
  assign out_tdata = {1'b0, res_count, res_position, res_status};

endmodule
